### sv/sem_pkg.sv
package sem_pkg;

  // Fixed field widths of the pixel stream and the result items.
  localparam int PIX_W      = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 12;
  localparam int MAG_W      = 11;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register reset values.
  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(640);
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(480);

  // Arithmetic widths: a weighted column sum of three pixels is at most
  // 4 * 255, its square stays below 2^20 and the sum of two squares below 2^21.
  localparam int GRAD_W  = PIX_W + 2;
  localparam int SQR_W   = 2 * GRAD_W;
  localparam int SUM_W   = SQR_W + 1;
  localparam int TRIAL_W = SUM_W + 2;

  // Queue between the front and the back, and the result queue.
  // Both depths must be powers of two.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam int R_DEPTH = 16;
  localparam int R_PTR_W = $clog2(R_DEPTH);
  localparam int R_CNT_W = $clog2(R_DEPTH + 1);

  // Effective frame size after clamping.
  typedef struct packed {
    logic [CFG_W_W-1:0] w;
    logic [CFG_H_W-1:0] h;
  } cfg_t;

  // Position data that travels with an interior pixel.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } res_info_t;

  // The 3x3 neighbourhood of one interior pixel, middle center not needed.
  typedef struct packed {
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] ml;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] tm;
    logic [PIX_W-1:0] bm;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] mr;
    logic [PIX_W-1:0] br;
    res_info_t        info;
  } win_pkt_t;

  typedef struct packed {
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    res_info_t        info;
  } res_t;

endpackage

### sv/sem_ram.sv
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/sem_front.sv
module sem_front import sem_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             push,
  input  logic [PIX_W-1:0] pixel,
  input  logic             frame_start,
  output logic             full,
  input  q_status_t        q_stat,
  output logic             pkt_push,
  output win_pkt_t         pkt
);

  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;

  logic                 accept;
  logic [COL_W-1:0]     c0;
  logic [ROW_W-1:0]     r0;
  logic [CFG_W_W-1:0]   c0x;
  logic [ROW_W-1:0]     row_inc;
  logic                 active;
  logic                 last_col;
  logic                 interior;
  logic                 last_pix;

  // Second stage: the pixel whose line entries are being read.
  logic             s1_vld;
  logic [COL_W-1:0] s1_col;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_interior;
  res_info_t        s1_info;

  logic [PIX_W-1:0] upper_rdata, middle_rdata;
  logic [PIX_W-1:0] top_eff, mid_eff;
  logic             fwd_vld;
  logic [PIX_W-1:0] fwd_top, fwd_mid;
  logic [PIX_W-1:0] win [6];

  assign accept = push && !full;
  assign c0     = frame_start ? '0 : column_count;
  assign r0     = frame_start ? '0 : row_count;
  assign c0x    = CFG_W_W'(c0);
  assign active = r0 < cfg.h;

  assign last_col = (c0x + CFG_W_W'(1)) >= cfg.w;
  assign interior = (c0 >= COL_W'(2)) && (r0 >= ROW_W'(2)) && (c0x < cfg.w);
  assign last_pix = ((c0x + CFG_W_W'(1)) == cfg.w) &&
                    ((CFG_H_W'(r0) + CFG_H_W'(1)) == cfg.h);
  assign row_inc  = r0 + ROW_W'(1);

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (frame_start) begin
        column_count_next = '0;
        row_count_next    = '0;
      end
      if (active) begin
        if (last_col) begin
          column_count_next = '0;
          // A row counter that wraps parks at the height, which stops the frame.
          row_count_next = (row_inc == '0) ? ROW_W'(cfg.h) : row_inc;
        end else begin
          column_count_next = c0 + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_vld       <= 1'b0;
      fwd_vld      <= 1'b0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      s1_vld       <= accept && active;
      fwd_vld      <= accept && active && s1_vld && (c0 == s1_col);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active) begin
      s1_col      <= c0;
      s1_pix      <= pixel;
      s1_interior <= interior;
      s1_info     <= '{col: c0 - COL_W'(1), row: r0 - ROW_W'(1), last: last_pix};
    end
    // The entry written this cycle is read for the next pixel at the same edge.
    fwd_top <= mid_eff;
    fwd_mid <= s1_pix;
  end

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_vld),
    .waddr (s1_col),
    .wdata (mid_eff),
    .re    (accept && active),
    .raddr (c0),
    .rdata (upper_rdata)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_vld),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (accept && active),
    .raddr (c0),
    .rdata (middle_rdata)
  );

  assign top_eff = fwd_vld ? fwd_top : upper_rdata;
  assign mid_eff = fwd_vld ? fwd_mid : middle_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_vld) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_eff;
      win[4] <= mid_eff;
      win[5] <= s1_pix;
    end
  end

  assign pkt_push = s1_vld && s1_interior;

  always_comb begin
    pkt.tl   = win[0];
    pkt.ml   = win[1];
    pkt.bl   = win[2];
    pkt.tm   = win[3];
    pkt.bm   = win[5];
    pkt.tr   = top_eff;
    pkt.mr   = mid_eff;
    pkt.br   = s1_pix;
    pkt.info = s1_info;
  end

  // Leave room for the packet that the second stage may still push.
  assign full = ((Q_CNT_W + 1)'(q_stat.count) + (Q_CNT_W + 1)'(pkt_push)) >=
                (Q_CNT_W + 1)'(Q_DEPTH);

endmodule

### sv/sem_queue.sv
module sem_queue import sem_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  win_pkt_t  din,
  input  logic      pop,
  output win_pkt_t  dout,
  output q_status_t status
);

  win_pkt_t           entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  assign dout         = entries[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);

endmodule

### sv/sem_back.sv
module sem_back import sem_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_status_t q_stat,
  input  win_pkt_t  q_dout,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output res_t      result
);

  localparam int SQ_STAGES = MAG_W;

  // Slots of the result queue that are taken or promised to work in flight.
  logic [R_CNT_W-1:0] reserved, reserved_next;
  logic               out_pop;

  logic [GRAD_W-1:0] pos_x, neg_x, pos_y, neg_y;

  logic              g_vld;
  logic [GRAD_W-1:0] gx_abs, gy_abs;
  res_info_t         g_info;

  logic             m_vld;
  logic [SQR_W-1:0] gx2, gy2;
  res_info_t        m_info;

  logic             sq_vld  [SQ_STAGES+1];
  logic [SUM_W-1:0] sq_rem  [SQ_STAGES+1];
  logic [MAG_W-1:0] sq_root [SQ_STAGES+1];
  res_info_t        sq_info [SQ_STAGES+1];

  res_t               rq [R_DEPTH];
  logic [R_PTR_W-1:0] rq_wr, rq_rd;
  logic [R_CNT_W-1:0] rq_count;
  logic               rq_push;

  assign q_pop   = !q_stat.empty && (reserved < R_CNT_W'(R_DEPTH));
  assign out_pop = pop && !empty;
  assign reserved_next = reserved + R_CNT_W'(q_pop) - R_CNT_W'(out_pop);

  always_comb begin
    pos_x = GRAD_W'(q_dout.tr) + (GRAD_W'(q_dout.mr) << 1) + GRAD_W'(q_dout.br);
    neg_x = GRAD_W'(q_dout.tl) + (GRAD_W'(q_dout.ml) << 1) + GRAD_W'(q_dout.bl);
    pos_y = GRAD_W'(q_dout.bl) + (GRAD_W'(q_dout.bm) << 1) + GRAD_W'(q_dout.br);
    neg_y = GRAD_W'(q_dout.tl) + (GRAD_W'(q_dout.tm) << 1) + GRAD_W'(q_dout.tr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved  <= '0;
      g_vld     <= 1'b0;
      m_vld     <= 1'b0;
      sq_vld[0] <= 1'b0;
    end else begin
      reserved  <= reserved_next;
      g_vld     <= q_pop;
      m_vld     <= g_vld;
      sq_vld[0] <= m_vld;
    end
  end

  // The square of a gradient equals the square of its magnitude.
  always_ff @(posedge clk) begin
    gx_abs     <= (pos_x >= neg_x) ? pos_x - neg_x : neg_x - pos_x;
    gy_abs     <= (pos_y >= neg_y) ? pos_y - neg_y : neg_y - pos_y;
    g_info     <= q_dout.info;
    gx2        <= SQR_W'(gx_abs) * SQR_W'(gx_abs);
    gy2        <= SQR_W'(gy_abs) * SQR_W'(gy_abs);
    m_info     <= g_info;
    sq_rem[0]  <= SUM_W'(gx2) + SUM_W'(gy2);
    sq_root[0] <= '0;
    sq_info[0] <= m_info;
  end

  // Square root, one result bit per stage, most significant first. The
  // remainder is the radicand minus the square of the partial root.
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    localparam int B = MAG_W - 1 - k;
    logic [TRIAL_W-1:0] trial;
    logic               take;

    assign trial = (TRIAL_W'(sq_root[k]) << (B + 1)) | (TRIAL_W'(1) << (2 * B));
    assign take  = TRIAL_W'(sq_rem[k]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_rem[k+1]  <= take ? SUM_W'(TRIAL_W'(sq_rem[k]) - trial) : sq_rem[k];
      sq_root[k+1] <= take ? (sq_root[k] | (MAG_W'(1) << B)) : sq_root[k];
      sq_info[k+1] <= sq_info[k];
    end
  end

  assign rq_push = sq_vld[SQ_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= '0;
      rq_rd    <= '0;
      rq_count <= '0;
    end else begin
      if (rq_push) begin
        rq_wr <= rq_wr + R_PTR_W'(1);
      end
      if (out_pop) begin
        rq_rd <= rq_rd + R_PTR_W'(1);
      end
      rq_count <= rq_count + R_CNT_W'(rq_push) - R_CNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq[rq_wr] <= '{mag: sq_root[SQ_STAGES], info: sq_info[SQ_STAGES]};
    end
  end

  assign empty  = (rq_count == '0);
  assign result = rq[rq_rd];

endmodule

### sv/sobel_edge_magnitude.sv
// Throughput: one pixel per cycle, sustained while results are taken.
// Reset (rst, synchronous, active high) clears counters, queues and pipeline
// valids; the registers return to 640 x 480. The line stores are not cleared.
module sobel_edge_magnitude import sem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Pixel stream
  input  logic                  push,
  output logic                  full,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  frame_start,
  // Result stream
  output logic                  empty,
  input  logic                  pop,
  output logic [MAG_W-1:0]      magnitude,
  output logic [COL_W-1:0]      center_col,
  output logic [ROW_W-1:0]      center_row,
  output logic                  last_of_frame
);

  // The block is split in two halves joined by a short packet queue.
  //
  // The front transfers pixels in, keeps the column and row counters, reads
  // and writes the two line stores and the window register, and decides
  // whether a pixel is the lower right corner of an interior neighbourhood.
  // Only those pixels produce a packet with the eight neighbours that the
  // gradients need. The line stores are single-port-write RAMs with a
  // registered read; the entry for a column is read at the transfer edge and
  // rewritten the cycle after. When a frame restart makes the next pixel read
  // the column that is just being written, the written data is forwarded.
  //
  // The back pops packets, forms the absolute gradients, squares and adds
  // them, and takes the integer square root in eleven pipelined stages, one
  // result bit per stage. Finished results wait in a sixteen-entry result
  // queue. A packet is popped only when a slot of that queue is reserved for
  // it, so the pipeline never stalls; backpressure from the result side
  // reaches the pixel side as full through the packet queue.
  //
  // Rate: the front takes one pixel per cycle while full is low, limited by
  // the single read port of each line store. The back sustains one result
  // per cycle as long as results are popped, since the reservation loop is
  // shorter than the result queue.

  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  logic [CFG_W_W-1:0] image_width;
  logic [CFG_H_W-1:0] image_height;
  logic               cfg_write;
  logic               reg_idx;
  cfg_t               cfg;

  q_status_t q_stat;
  logic      pkt_push;
  win_pkt_t  pkt;
  win_pkt_t  q_dout;
  logic      q_pop;
  res_t      result;

  // Registers sit 4 bytes apart; the index is address bit 2.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_IDX_WIDTH:  image_width  <= pwdata[CFG_W_W-1:0];
        REG_IDX_HEIGHT: image_height <= pwdata[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IDX_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IDX_HEIGHT: prdata = APB_DATA_W'(image_height);
      default:        prdata = '0;
    endcase
  end

  // The width is clamped to the line store depth and to at least three
  // columns; the height to at least three rows.
  always_comb begin
    if (image_width < CFG_W_W'(3)) begin
      cfg.w = CFG_W_W'(3);
    end else if (image_width > CFG_W_W'(MAX_WIDTH)) begin
      cfg.w = CFG_W_W'(MAX_WIDTH);
    end else begin
      cfg.w = image_width;
    end
    cfg.h = (image_height < CFG_H_W'(3)) ? CFG_H_W'(3) : image_height;
  end

  sem_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .pixel       (pixel),
    .frame_start (frame_start),
    .full        (full),
    .q_stat      (q_stat),
    .pkt_push    (pkt_push),
    .pkt         (pkt)
  );

  sem_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (pkt_push),
    .din    (pkt),
    .pop    (q_pop),
    .dout   (q_dout),
    .status (q_stat)
  );

  sem_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .q_dout (q_dout),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  assign magnitude     = result.mag;
  assign center_col    = result.info.col;
  assign center_row    = result.info.row;
  assign last_of_frame = result.info.last;

endmodule

### sv/sem_checker.sv
module sem_checker import sem_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  pready,
  input logic                  push,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic [MAG_W-1:0]      magnitude,
  input logic [COL_W-1:0]      center_col,
  input logic [ROW_W-1:0]      center_row,
  input logic                  last_of_frame
);

  // After reset nothing is waiting and the pixel side is open.
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  // A result that is not taken stays on the ports unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(magnitude) && $stable(center_col) &&
                          $stable(center_row) && $stable(last_of_frame)))
    else $error("waiting result changed");

  // A width write reads back in the following cycle.
  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && !paddr[2]) |=>
      (paddr[2] || prdata == APB_DATA_W'($past(pwdata[CFG_W_W-1:0]))))
    else $error("width register read back wrong");

  // A height write reads back in the following cycle.
  a_height_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[2]) |=>
      (!paddr[2] || prdata == APB_DATA_W'($past(pwdata[CFG_H_W-1:0]))))
    else $error("height register read back wrong");

  // Transfers only, so push is used alongside full.
  a_push_known: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !$isunknown(full))
    else $error("full unknown after a pixel transfer");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);

### sim/sobel_checker.sv
`timescale 1ns / 1ps

package sobel_tb_pkg;

  // Register indexes of the configuration port. Register i sits at byte address 4*i.
  typedef enum int {
    REG_IMAGE_WIDTH  = 0,
    REG_IMAGE_HEIGHT = 1
  } sobel_reg_e;

endpackage

module sobel_checker import sem_pkg::*; import sobel_tb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  push,
  input  logic                  full,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  frame_start,
  input  logic                  pop,
  input  logic                  empty,
  input  logic [MAG_W-1:0]      magnitude,
  input  logic [COL_W-1:0]      center_col,
  input  logic [ROW_W-1:0]      center_row,
  input  logic                  last_of_frame,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct {
    logic [MAG_W-1:0] magnitude;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } magnitude_entry_t;

  magnitude_entry_t   pending_magnitudes[$];
  logic [CFG_W_W-1:0] width_reg;
  logic [CFG_H_W-1:0] height_reg;
  bit   [PIX_W-1:0]   upper_line [MAX_WIDTH];
  bit   [PIX_W-1:0]   middle_line [MAX_WIDTH];
  bit   [PIX_W-1:0]   window_px [6];
  logic [COL_W-1:0]   col_cnt;
  logic [ROW_W-1:0]   row_cnt;
  int                 errors = 0;

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_result();
    magnitude_entry_t want;
    if (pending_magnitudes.size() == 0) begin
      $display("%0t: result with nothing expected, actual magnitude %0d col %0d row %0d",
               $time, magnitude, center_col, center_row);
      errors++;
    end else begin
      want = pending_magnitudes.pop_front();
      errors += field_differs("magnitude", 32'(want.magnitude), 32'(magnitude));
      errors += field_differs("center_col", 32'(want.col), 32'(center_col));
      errors += field_differs("center_row", 32'(want.row), 32'(center_row));
      errors += field_differs("last_of_frame", 32'(want.last), 32'(last_of_frame));
    end
  endtask

  // Moves the 3x3 neighbourhood on by one pixel and queues the magnitude
  // when the pixel completes the window of an interior pixel.
  task automatic track_pixel(input logic [PIX_W-1:0] p, input logic fs);
    int               w;
    int               h;
    int               c;
    int               r;
    int               gx;
    int               gy;
    int               sum;
    int               root;
    bit               last_col;
    bit [PIX_W-1:0]   top_px;
    bit [PIX_W-1:0]   mid_px;
    magnitude_entry_t res;
    w = int'(width_reg);
    h = int'(height_reg);
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 3) h = 3;
    if (fs) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    if (int'(row_cnt) >= h) return;
    c = int'(col_cnt);
    r = int'(row_cnt);
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
    last_col = (c + 1 >= w);
    top_px = upper_line[c];
    mid_px = middle_line[c];
    if (c >= 2 && r >= 2 && c < w) begin
      gx = (int'(top_px) + 2 * int'(mid_px) + int'(p))
         - (int'(window_px[0]) + 2 * int'(window_px[1]) + int'(window_px[2]));
      gy = (int'(window_px[2]) + 2 * int'(window_px[5]) + int'(p))
         - (int'(window_px[0]) + 2 * int'(window_px[3]) + int'(top_px));
      sum = gx * gx + gy * gy;
      root = int'($floor($sqrt(real'(sum))));
      while (root * root > sum) root--;
      while ((root + 1) * (root + 1) <= sum) root++;
      if (root > 2047) root = 2047;
      res.magnitude = MAG_W'(root);
      res.col = COL_W'(c - 1);
      res.row = ROW_W'(r - 1);
      res.last = (c + 1 == w) && (r + 1 == h);
      pending_magnitudes.insert(pending_magnitudes.size(), res);
    end
    window_px[0] = window_px[3];
    window_px[1] = window_px[4];
    window_px[2] = window_px[5];
    window_px[3] = top_px;
    window_px[4] = mid_px;
    window_px[5] = p;
    upper_line[c] = mid_px;
    middle_line[c] = p;
    if (last_col) begin
      col_cnt = '0;
      row_cnt = row_cnt + ROW_W'(1);
      if (row_cnt == '0) row_cnt = ROW_W'(h);
    end else begin
      col_cnt = COL_W'(c + 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (window_px[i]) window_px[i] = '0;
      col_cnt = '0;
      row_cnt = '0;
      pending_magnitudes.delete();
    end else begin
      // A result leaves long after the pixel that caused it, so the result
      // side is checked before this edge's pixel is modeled.
      if (pop && !empty) check_result();
      if (push && !full) track_pixel(pixel, frame_start);
      if (psel && penable && pwrite && pready) begin
        case (int'(paddr) / 4)
          REG_IMAGE_WIDTH:  width_reg = pwdata[CFG_W_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = pwdata[CFG_H_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending_count <= pending_magnitudes.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sem_pkg::*;
  import sobel_tb_pkg::*;

  // Percentage of cycles in which either side holds back, and the wait
  // that lets the pipeline empty after the last expected result is seen.
  localparam int IDLE_PCT     = 15;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 50000;

  // Pixel patterns for whole frames.
  typedef enum int {
    PIX_RANDOM,
    PIX_EXTREME,
    PIX_RAMP,
    PIX_FLAT
  } pix_style_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  push = 1'b0;
  logic                  full;
  logic [PIX_W-1:0]      pixel = '0;
  logic                  frame_start = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [MAG_W-1:0]      magnitude;
  logic [COL_W-1:0]      center_col;
  logic [ROW_W-1:0]      center_row;
  logic                  last_of_frame;

  // When set, neither side idles: the block has to take one pixel per cycle.
  logic                  steady = 1'b0;
  int                    fail_count;
  int                    pending_count;
  int unsigned           cycle_count = 0;

  sobel_edge_magnitude u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .pixel         (pixel),
    .frame_start   (frame_start),
    .empty         (empty),
    .pop           (pop),
    .magnitude     (magnitude),
    .center_col    (center_col),
    .center_row    (center_row),
    .last_of_frame (last_of_frame)
  );

  sobel_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .push          (push),
    .full          (full),
    .pixel         (pixel),
    .frame_start   (frame_start),
    .pop           (pop),
    .empty         (empty),
    .magnitude     (magnitude),
    .center_col    (center_col),
    .center_row    (center_row),
    .last_of_frame (last_of_frame),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // The run is cut off if it hangs, for example when results stop coming.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sobel_edge_magnitude test failed");
      $finish;
    end
  end

  // The result side takes a transfer in most cycles and stalls at random in
  // the rest, so the result queue fills now and then and pushes back on the
  // pixel side.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel(input pix_style_e style, input int idx);
    case (style)
      PIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      PIX_RAMP:    return PIX_W'(idx * 29);
      PIX_FLAT:    return 8'hFF;
      default:     return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // One pixel transfer. While the sender idles, the data lines carry noise,
  // including a raised frame_start, which the block has to ignore.
  task automatic send_pixel(input logic [PIX_W-1:0] value, input logic first);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      pixel <= PIX_W'($urandom_range(255));
      frame_start <= 1'($urandom_range(1));
      @(posedge clk);
    end
    push <= 1'b1;
    pixel <= value;
    frame_start <= first;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // A run of pixels; with first set the run opens a new frame.
  task automatic send_run(input int count, input pix_style_e style, input bit first);
    for (int i = 0; i < count; i++) begin
      send_pixel(pick_pixel(style, i), first && (i == 0));
    end
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // that ends the access cycle. The bus goes idle after each write.
  task automatic apb_write(input sobel_reg_e idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * int'(idx));
    pwdata <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Stops the pixel stream and waits until every expected result has been
  // taken. Pixels that give no result may still be in flight at that point,
  // so a further wait covers the pipeline latency.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int width_val, input int height_val);
    settle();
    apb_write(REG_IMAGE_WIDTH, width_val);
    apb_write(REG_IMAGE_HEIGHT, height_val);
  endtask

  initial begin
    int         w;
    int         h;
    int         n;
    int         kind;
    int         items;
    pix_style_e style;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Smallest frame: a single interior pixel, which is also the last of its
    // frame. The two pixels after it lie beyond the last row and are dropped.
    configure(3, 3);
    send_run(9, PIX_EXTREME, 1'b1);
    send_run(2, PIX_RANDOM, 1'b0);

    // Zero in both registers is clamped up to the smallest frame.
    configure(0, 0);
    send_run(9, PIX_RAMP, 1'b1);
    send_run(9, PIX_FLAT, 1'b1);

    // A frame abandoned after seven pixels by a new frame_start, then a
    // frame whose width shrinks from five to three while the block is idle
    // in the middle of the third row. The pixel at column three then closes
    // that row without a result, and the fourth row runs at the new width.
    configure(5, 4);
    send_run(7, PIX_RANDOM, 1'b1);
    send_run(13, PIX_RANDOM, 1'b1);
    settle();
    apb_write(REG_IMAGE_WIDTH, 3);
    send_run(4, PIX_EXTREME, 1'b0);

    // Widest frame: the register value is above the line store size and is
    // clamped to it, so the first row closes after MAX_WIDTH pixels. Once the
    // second row holds six pixels, the width drops to four; the next pixel
    // closes that row and the third row gives results. Both sides run
    // without a single idle cycle through the long first run.
    configure(2047, 3);
    steady <= 1'b1;
    send_run(MAX_WIDTH + 6, PIX_RANDOM, 1'b1);
    settle();
    steady <= 1'b0;
    apb_write(REG_IMAGE_WIDTH, 4);
    send_run(5, PIX_RANDOM, 1'b0);

    // Tallest frame, cut short after twenty rows.
    configure(3, 4095);
    send_run(60, PIX_EXTREME, 1'b1);

    // Random frames. Most are complete frames with a pixel pattern picked at
    // random; some are cut short by the next frame_start, some shrink
    // mid-frame, and some carry a few extra pixels past the last row.
    items = 0;
    w = 3;
    h = 3;
    while (items < RANDOM_ITEMS) begin
      if (items == 0 || $urandom_range(3) == 0) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
        h = ($urandom_range(9) == 0) ? $urandom_range(11, 24) : $urandom_range(3, 10);
        configure((w == 3 && $urandom_range(1)) ? $urandom_range(2) : w,
                  (h == 3 && $urandom_range(1)) ? $urandom_range(2) : h);
      end
      style = pix_style_e'($urandom_range(3));
      kind = $urandom_range(9);
      if (kind == 0) begin
        n = $urandom_range(1, w * h - 1);
        send_run(n, style, 1'b1);
        items += n;
      end else if (kind == 1 && w > 3) begin
        // Shrinking the width mid-frame only ever reads line entries that
        // this frame has already written.
        n = 2 * w + $urandom_range(w - 1);
        send_run(n, style, 1'b1);
        settle();
        w = $urandom_range(3, w - 1);
        apb_write(REG_IMAGE_WIDTH, w);
        if ($urandom_range(1)) begin
          h = $urandom_range(3, h + 2);
          apb_write(REG_IMAGE_HEIGHT, h);
        end
        send_run(w * h, style, 1'b0);
        items += n + w * h;
      end else begin
        send_run(w * h, style, 1'b1);
        items += w * h;
        if ($urandom_range(3) == 0) send_run($urandom_range(1, 3), PIX_RANDOM, 1'b0);
      end
    end

    settle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("sobel_edge_magnitude test passed");
    end else begin
      $display("sobel_edge_magnitude test failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/sem_pkg.sv
sv/sem_ram.sv
sv/sem_front.sv
sv/sem_queue.sv
sv/sem_back.sv
sv/sobel_edge_magnitude.sv
sv/sem_checker.sv
sim/sobel_checker.sv
sim/testbench.sv
